>>> hw/rtl/hsv2rgb_pkg.sv
// Shared types and fixed constants of the HSV to RGB converter.
package hsv2rgb_pkg;

   localparam int FIELD_W = 16;
   localparam int CHAN_W  = 8;

   typedef logic signed [FIELD_W-1:0] field_type;
   typedef logic [CHAN_W-1:0]         chan_type;

   // Hue in 1/16 degree, saturation and value in 1/16 percent.
   localparam int HUE_TURN     = 5760;
   localparam int PCT_FULL     = 1600;
   localparam int SECTOR_UNITS = 960;

   // Hue wrap: bias by six turns (34560) to make it positive. The sign-bit flip already adds
   // 32768, so the remaining offset is 1792. HUE_TURN = HUE_DIV << HUE_LO_W.
   localparam int HUE_OFFSET = 1792;
   localparam int HUE_LO_W   = 7;
   localparam int HUE_DIV    = 45;
   localparam int RECIP_45   = 1456;   // floor(2^16 / 45)

endpackage

>>> hw/rtl/hsv2rgb_if.sv
// Valid/ready stream interfaces for colour requests and RGB responses.
interface hsv2rgb_req_if import hsv2rgb_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type hue;
   field_type saturation;
   field_type brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

interface hsv2rgb_rsp_if import hsv2rgb_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> hw/rtl/hsv_to_rgb_converter_unit.sv
// HSV to RGB converter: six-stage pipeline, one colour per cycle unless stalled.
//
//   channel  dir  handshake           payload
//   req_if   in   valid/ready         hue, saturation, brightness (s16, 1/16 units)
//   rsp_if   out  valid/ready         red, green, blue (u8)
//
// A new transaction can enter every cycle unless a stall on rsp_if.ready has
// filled the pipeline back to the input. Each stage holds while the stage
// after it is full and stalled, so ready reaches the input through a chain of
// six stage-full terms. The multipliers (hue wrap reciprocal, the two percent
// reciprocals, the sector reciprocal, V*S and C*(1-D)) set the stage depth.
// Synchronous reset empties the pipeline; there is no other state.
module hsv_to_rgb_converter_unit import hsv2rgb_pkg::*; #(
   parameter int INTERNAL_FRACTION_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   hsv2rgb_req_if.sink    req_if,
   hsv2rgb_rsp_if.source  rsp_if
);

   localparam int F      = INTERNAL_FRACTION_BITS;
   localparam int W      = F + 1;               // fraction values up to 1.0
   localparam int PCT_W  = $clog2(PCT_FULL + 1);
   localparam int HUE_W  = $clog2(HUE_TURN);
   localparam int HUE_HI_W = 17 - HUE_LO_W;
   localparam int SP_W   = F + 12;              // percent reciprocal product
   localparam int HP_W   = F + 17;              // sector reciprocal product
   localparam int HR_W   = F + 14;              // sector remainder check
   localparam int HH_W   = F + 3;               // hue in sectors, below 6.0
   localparam int TB_W   = F + 10;

   localparam logic [F:0]      ONE      = W'(64'd1 << F);
   localparam logic [F:0]      RECIP_S  = W'((64'd1 << (F + 11)) / 64'(PCT_FULL));
   localparam logic [F+3:0]    RECIP_H  = (F + 4)'((64'd1 << (F + 13)) / 64'(SECTOR_UNITS));
   localparam logic [HH_W-1:0] HH_END   = HH_W'(64'd6 << F);

   typedef enum logic [2:0] {
      SECT_RG = 3'd0,
      SECT_GR = 3'd1,
      SECT_GB = 3'd2,
      SECT_BG = 3'd3,
      SECT_BR = 3'd4,
      SECT_RB = 3'd5
   } sector_type;

   function automatic logic [PCT_W-1:0] clamp_pct(input field_type p);
      if (p[FIELD_W-1]) begin
         clamp_pct = '0;
      end else if (p[FIELD_W-2:0] > (FIELD_W - 1)'(PCT_FULL)) begin
         clamp_pct = PCT_W'(PCT_FULL);
      end else begin
         clamp_pct = p[PCT_W-1:0];
      end
   endfunction

   // Finish count * 2^F / 1600 from an estimate that is at most one low.
   function automatic logic [F:0] fix_pct(input logic [PCT_W-1:0] cnt, input logic [F:0] q);
      logic [SP_W-1:0] num;
      logic [SP_W-1:0] base;
      num  = SP_W'(cnt) << F;
      base = SP_W'(q) * SP_W'(PCT_FULL);
      if ((num - base) >= SP_W'(PCT_FULL)) begin
         fix_pct = q + W'(1);
      end else begin
         fix_pct = q;
      end
   endfunction

   function automatic chan_type to_byte(input logic [F+1:0] sum);
      logic [TB_W-1:0] t;
      t = (TB_W'(sum) << 8) - TB_W'(sum) + TB_W'(ONE >> 1);
      if (t[TB_W-1:F] > 10'd255) begin
         to_byte = 8'hFF;
      end else begin
         to_byte = t[F+7:F];
      end
   endfunction

   // Stage enables and valid bits
   logic [6:1] vld_ff;
   logic [6:1] vld_in;
   logic [6:1] adv;

   assign adv[6] = !vld_ff[6] || rsp_if.ready;
   assign adv[5] = !vld_ff[5] || adv[6];
   assign adv[4] = !vld_ff[4] || adv[5];
   assign adv[3] = !vld_ff[3] || adv[4];
   assign adv[2] = !vld_ff[2] || adv[3];
   assign adv[1] = !vld_ff[1] || adv[2];

   assign vld_in = {vld_ff[5:1], req_if.valid};
   assign req_if.ready = adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= 6; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // Stage 1: bias hue, estimate its turn count, clamp percentages
   logic [15:0]           hue_flip;
   logic [16:0]           hue_off;
   logic [20:0]           qa_prod;
   logic [HUE_HI_W-1:0]   hue_hi_s1_ff;
   logic [HUE_LO_W-1:0]   hue_lo_s1_ff;
   logic [3:0]            qa_s1_ff, qa_in;
   logic [PCT_W-1:0]      sc_s1_ff, vc_s1_ff;

   always_comb begin
      hue_flip = {~req_if.hue[15], req_if.hue[14:0]};
      hue_off  = {1'b0, hue_flip} + 17'(HUE_OFFSET);
      qa_prod  = 21'(hue_off[16:HUE_LO_W]) * 21'(RECIP_45);
      qa_in    = qa_prod[19:16];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         hue_hi_s1_ff <= hue_off[16:HUE_LO_W];
         hue_lo_s1_ff <= hue_off[HUE_LO_W-1:0];
         qa_s1_ff     <= qa_in;
         sc_s1_ff     <= clamp_pct(req_if.saturation);
         vc_s1_ff     <= clamp_pct(req_if.brightness);
      end
   end

   // Stage 2: wrapped hue, percent reciprocal estimates
   logic [HUE_HI_W-1:0] ra_raw, ra_fix;
   logic [HUE_W-1:0]    hw_in, hw_s2_ff;
   logic [SP_W-1:0]     sq_prod, vq_prod;
   logic [F:0]          sq_s2_ff, vq_s2_ff;
   logic [PCT_W-1:0]    sc_s2_ff, vc_s2_ff;

   always_comb begin
      ra_raw  = hue_hi_s1_ff - HUE_HI_W'(HUE_HI_W'(qa_s1_ff) * HUE_HI_W'(HUE_DIV));
      ra_fix  = (ra_raw >= HUE_HI_W'(HUE_DIV)) ? ra_raw - HUE_HI_W'(HUE_DIV) : ra_raw;
      hw_in   = {ra_fix[HUE_W-HUE_LO_W-1:0], hue_lo_s1_ff};
      sq_prod = SP_W'(sc_s1_ff) * SP_W'(RECIP_S);
      vq_prod = SP_W'(vc_s1_ff) * SP_W'(RECIP_S);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         hw_s2_ff <= hw_in;
         sq_s2_ff <= sq_prod[F+11:11];
         vq_s2_ff <= vq_prod[F+11:11];
         sc_s2_ff <= sc_s1_ff;
         vc_s2_ff <= vc_s1_ff;
      end
   end

   // Stage 3: correct S and V, estimate hue in sectors
   logic [HP_W-1:0]   hq_prod;
   logic [HH_W-1:0]   hq_s3_ff;
   logic [HUE_W-1:0]  hw_s3_ff;
   logic [F:0]        s_s3_ff, v_s3_ff;

   assign hq_prod = HP_W'(hw_s2_ff) * HP_W'(RECIP_H);

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s_s3_ff  <= fix_pct(sc_s2_ff, sq_s2_ff);
         v_s3_ff  <= fix_pct(vc_s2_ff, vq_s2_ff);
         hq_s3_ff <= hq_prod[F+15:13];
         hw_s3_ff <= hw_s2_ff;
      end
   end

   // Stage 4: correct hue in sectors, chroma
   logic [HR_W-1:0]   hr_num, hr_base;
   logic [HH_W-1:0]   hh_in, hh_s4_ff;
   logic [2*W-1:0]    c_prod;
   logic [F:0]        c_s4_ff, v_s4_ff;

   always_comb begin
      hr_num  = HR_W'(hw_s3_ff) << F;
      hr_base = HR_W'(hq_s3_ff) * HR_W'(SECTOR_UNITS);
      hh_in   = ((hr_num - hr_base) >= HR_W'(SECTOR_UNITS)) ? hq_s3_ff + HH_W'(1) : hq_s3_ff;
      c_prod  = (2 * W)'(v_s3_ff) * (2 * W)'(s_s3_ff);
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         hh_s4_ff <= hh_in;
         c_s4_ff  <= c_prod[2*F:F];
         v_s4_ff  <= v_s3_ff;
      end
   end

   // Stage 5: sector, second component, offset
   logic [F:0]     rem2, tri_d, span;
   logic [2*W-1:0] x_prod;
   sector_type     sect_s5_ff;
   logic [F:0]     c_s5_ff, x_s5_ff, m_s5_ff;

   always_comb begin
      rem2   = hh_s4_ff[F:0];
      tri_d  = (rem2 >= ONE) ? rem2 - ONE : ONE - rem2;
      span   = ONE - tri_d;
      x_prod = (2 * W)'(c_s4_ff) * (2 * W)'(span);
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         sect_s5_ff <= sector_type'(hh_s4_ff[F+2:F]);
         c_s5_ff    <= c_s4_ff;
         x_s5_ff    <= x_prod[2*F:F];
         m_s5_ff    <= v_s4_ff - c_s4_ff;
      end
   end

   // Stage 6: route components, add offset, scale to bytes
   logic [F:0]   r_cmp, g_cmp, b_cmp;
   chan_type     red_ff, green_ff, blue_ff;

   always_comb begin
      unique case (sect_s5_ff)
         SECT_RG: begin r_cmp = c_s5_ff; g_cmp = x_s5_ff; b_cmp = '0;      end
         SECT_GR: begin r_cmp = x_s5_ff; g_cmp = c_s5_ff; b_cmp = '0;      end
         SECT_GB: begin r_cmp = '0;      g_cmp = c_s5_ff; b_cmp = x_s5_ff; end
         SECT_BG: begin r_cmp = '0;      g_cmp = x_s5_ff; b_cmp = c_s5_ff; end
         SECT_BR: begin r_cmp = x_s5_ff; g_cmp = '0;      b_cmp = c_s5_ff; end
         default: begin r_cmp = c_s5_ff; g_cmp = '0;      b_cmp = x_s5_ff; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         red_ff   <= to_byte((F + 2)'(r_cmp) + (F + 2)'(m_s5_ff));
         green_ff <= to_byte((F + 2)'(g_cmp) + (F + 2)'(m_s5_ff));
         blue_ff  <= to_byte((F + 2)'(b_cmp) + (F + 2)'(m_s5_ff));
      end
   end

   assign rsp_if.valid = vld_ff[6];
   assign rsp_if.red   = red_ff;
   assign rsp_if.green = green_ff;
   assign rsp_if.blue  = blue_ff;

   // Checks
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> vld_ff[1])
      else $error("accepted transaction did not enter the first stage");

   a_hue_wrapped: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> hw_s2_ff < HUE_W'(HUE_TURN))
      else $error("wrapped hue out of range");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (s_s3_ff <= ONE) && (v_s3_ff <= ONE))
      else $error("saturation or value above one");

   a_chroma_sector: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> (c_s4_ff <= v_s4_ff) && (hh_s4_ff < HH_END))
      else $error("chroma above value or hue beyond last sector");

endmodule
